// ===== hw/rtl/urx_pkg.sv =====
// ----------------------------------------------------------------------------
// urx_pkg
// Shared types and constants for the UART receive ring with error tally.
// ----------------------------------------------------------------------------
package urx_pkg;

    // Default ring size; the ring holds one entry fewer than this
    localparam int RING_DEPTH_DEF = 256;

    localparam int DATA_W  = 8;
    localparam int WORD_W  = 12;
    localparam int FILL_W  = 8;
    localparam int TALLY_W = 32;

    // Line error flag positions in the receive word
    localparam int FLAG_OVERRUN = 8;
    localparam int FLAG_BREAK   = 9;
    localparam int FLAG_PARITY  = 10;
    localparam int FLAG_FRAMING = 11;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_FLUSH   = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_OFF   = 2'd2,
        ST_DROP  = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [WORD_W-1:0]   rx_word;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   read_byte;
        logic [FILL_W-1:0]   fill_count;
        logic [TALLY_W-1:0]  error_total;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic exec;       // carry out the accepted operation
        logic byte_load;  // take the popped byte from the RAM read port
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_hit;    // current input is a pop that will read the ring
    } dp_stat_t;

endpackage

// ===== hw/rtl/urx_ram.sv =====
// ----------------------------------------------------------------------------
// urx_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module urx_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/urx_datapath.sv =====
// ----------------------------------------------------------------------------
// urx_datapath
// Pointers, fill count, error tally, ring storage and the result register.
// ----------------------------------------------------------------------------
module urx_datapath
    import urx_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  in_item_t   in_data,
    input  ctrl_cmd_t  cmd,
    output dp_stat_t   stat,
    output out_item_t  out_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int EXT_W = (PTR_W > FILL_W) ? PTR_W : FILL_W;
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);

    logic               enabled_reg;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   cnt_reg, cnt_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    out_item_t          out_reg;

    status_t            status_c;
    logic               is_empty, is_full, do_write, do_read;
    logic [2:0]         err_inc;
    logic [EXT_W-1:0]   cnt_ext;
    logic [FILL_W-1:0]  fill_c;
    logic [DATA_W-1:0]  ram_rdata;

    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg == LAST_POS);

    // Next state for the accepted operation
    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        cnt_next   = cnt_reg;
        tally_next = tally_reg;
        status_c   = ST_OK;
        do_write   = 1'b0;
        do_read    = 1'b0;
        err_inc    = 3'd0;
        if (!enabled_reg)
        begin
            status_c = ST_OFF;
        end
        else
        begin
            unique case (in_data.opcode)
                OP_PUSH:
                begin
                    err_inc = 3'(in_data.rx_word[FLAG_OVERRUN])
                            + 3'(in_data.rx_word[FLAG_BREAK])
                            + 3'(in_data.rx_word[FLAG_PARITY])
                            + 3'(in_data.rx_word[FLAG_FRAMING]);
                    if (is_full)
                    begin
                        err_inc  = err_inc + 3'd1;
                        status_c = ST_DROP;
                    end
                    else
                    begin
                        do_write = 1'b1;
                        wp_next  = (wp_reg == LAST_POS) ? '0 : wp_reg + PTR_W'(1);
                        cnt_next = cnt_reg + PTR_W'(1);
                    end
                    tally_next = tally_reg + TALLY_W'(err_inc);
                end
                OP_POP:
                begin
                    if (is_empty)
                    begin
                        status_c = ST_EMPTY;
                    end
                    else
                    begin
                        do_read  = 1'b1;
                        rp_next  = (rp_reg == LAST_POS) ? '0 : rp_reg + PTR_W'(1);
                        cnt_next = cnt_reg - PTR_W'(1);
                    end
                end
                OP_FLUSH:
                begin
                    wp_next  = '0;
                    rp_next  = '0;
                    cnt_next = '0;
                end
                OP_RESTART:
                begin
                    wp_next    = '0;
                    rp_next    = '0;
                    cnt_next   = '0;
                    tally_next = '0;
                end
                default:
                begin
                    status_c = ST_OK;
                end
            endcase
        end
    end

    assign stat.pop_hit = do_read;

    // Fill count saturates at the field's range
    assign cnt_ext = EXT_W'(cnt_next);
    assign fill_c  = (cnt_ext > EXT_W'(255)) ? 8'hFF : cnt_ext[FILL_W-1:0];

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            wp_reg      <= '0;
            rp_reg      <= '0;
            cnt_reg     <= '0;
            tally_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                enabled_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                wp_reg    <= wp_next;
                rp_reg    <= rp_next;
                cnt_reg   <= cnt_next;
                tally_reg <= tally_next;
            end
        end
    end

    // Result register; the popped byte is loaded from the RAM read port in S_READ
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_reg.status      <= status_c;
            out_reg.read_byte   <= '0;
            out_reg.fill_count  <= fill_c;
            out_reg.error_total <= tally_next;
        end
        else if (cmd.byte_load)
        begin
            out_reg.read_byte <= ram_rdata;
        end
    end

    assign out_data = out_reg;

    // Ring storage
    urx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.exec && do_write),
        .waddr (wp_reg),
        .wdata (in_data.rx_word[DATA_W-1:0]),
        .re    (cmd.exec && do_read),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

endmodule

// ===== hw/rtl/urx_ctrl.sv =====
// ----------------------------------------------------------------------------
// urx_ctrl
// Sequencer: accepts a beat, waits on the ring read for pops, holds out_valid.
// ----------------------------------------------------------------------------
module urx_ctrl
    import urx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // Take a beat only when the result register is free or being emptied
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign cmd.exec      = accept;
    assign cmd.byte_load = (state_reg == S_READ);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stat.pop_hit)
                    begin
                        state_next     = S_READ;
                        out_valid_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/uart_rx_ring_with_error_count.sv =====
// ----------------------------------------------------------------------------
// uart_rx_ring_with_error_count
// UART receive ring buffer with a wrapping line-error tally.
// Results are registered; a pop that reads the ring also waits on the registered
// RAM read port. One beat per cycle while the sink takes results; a pop that
// returns a byte holds off the next beat. Reset clears pointers, fill count,
// tally and enable; ring contents are left undefined until written.
// ----------------------------------------------------------------------------
module uart_rx_ring_with_error_count
    import urx_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    urx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    urx_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

    // A pop that reads the ring holds the result back until the ring read completes
    a_pop_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && stat.pop_hit) |=> !out_valid)
        else $error("result shown before ring read data");

    // Any other accepted beat yields a result on the next cycle
    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !stat.pop_hit) |=> out_valid)
        else $error("result missing after accepted beat");

    // A stalled result blocks new input
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while result stalled");

endmodule

// ===== verif/uart_rx_ring_with_error_count_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_rx_ring_with_error_count_tb
// Self-checking bench for the UART receive ring with its line-error tally.
// A short table of directed beats covers the disabled state, empty pops, every
// flag bit and the flush and restart commands. Random episodes follow: fills
// to overflow, drains past empty, mixed traffic and noise, with toggles of the
// enable bit between them. Each result is checked against the table or a predictor.
// ----------------------------------------------------------------------------
module uart_rx_ring_with_error_count_tb;
    import urx_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BEATS = 500;

    typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED, EP_NOISE} episode_t;

    typedef struct {
        bit        set_en;
        bit        en_val;
        in_item_t  beat;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Predictor state: ring contents, pointers, tally and enable bit
    logic [DATA_W-1:0]  ring_mem [RING_DEPTH_DEF];
    int                 wr_ptr = 0;
    int                 rd_ptr = 0;
    logic [TALLY_W-1:0] err_tally = '0;
    logic               rx_enabled = 1'b0;

    out_item_t expected_q [$];
    dir_row_t  dir_rows [$];
    int        n_errors = 0;
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    int        cycle_count = 0;

    uart_rx_ring_with_error_count #(
        .RING_DEPTH (RING_DEPTH_DEF)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Bytes held, saturated to the width of the fill field
    function automatic int ring_fill();
        int held;
        held = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + RING_DEPTH_DEF - rd_ptr;
        return (held > 255) ? 255 : held;
    endfunction

    function automatic bit ring_full();
        return ((wr_ptr + 1) % RING_DEPTH_DEF) == rd_ptr;
    endfunction

    // Apply one beat to the predicted state and return the expected result
    function automatic out_item_t rx_ring_predict(input in_item_t beat);
        out_item_t res;
        int        b;
        res.status    = ST_OK;
        res.read_byte = '0;
        if (!rx_enabled)
            res.status = ST_OFF;
        else
        begin
            case (beat.opcode)
                OP_PUSH:
                begin
                    for (b = FLAG_OVERRUN; b <= FLAG_FRAMING; b++)
                        if (beat.rx_word[b])
                            err_tally = err_tally + 1'b1;
                    if (!ring_full())
                    begin
                        ring_mem[wr_ptr] = beat.rx_word[DATA_W-1:0];
                        wr_ptr = (wr_ptr + 1) % RING_DEPTH_DEF;
                    end
                    else
                    begin
                        // dropped byte counts as one more error
                        err_tally  = err_tally + 1'b1;
                        res.status = ST_DROP;
                    end
                end
                OP_POP:
                begin
                    if (wr_ptr == rd_ptr)
                        res.status = ST_EMPTY;
                    else
                    begin
                        res.read_byte = ring_mem[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % RING_DEPTH_DEF;
                    end
                end
                OP_FLUSH:
                begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                end
                default:
                begin
                    wr_ptr    = 0;
                    rd_ptr    = 0;
                    err_tally = '0;
                end
            endcase
        end
        res.fill_count  = FILL_W'(ring_fill());
        res.error_total = err_tally;
        return res;
    endfunction

    function automatic in_item_t mk_beat(input opcode_t op, input logic [WORD_W-1:0] w);
        in_item_t beat;
        beat.opcode  = op;
        beat.rx_word = w;
        return beat;
    endfunction

    function automatic out_item_t mk_res(input status_t st, input logic [DATA_W-1:0] rb,
                                         input int fill, input int tally);
        out_item_t res;
        res.status      = st;
        res.read_byte   = rb;
        res.fill_count  = FILL_W'(fill);
        res.error_total = TALLY_W'(tally);
        return res;
    endfunction

    function automatic void add_row(input bit set_en, input bit en_val, input in_item_t beat,
                                    input bit typed, input out_item_t want);
        dir_row_t row;
        row.set_en = set_en;
        row.en_val = en_val;
        row.beat   = beat;
        row.typed  = typed;
        row.want   = want;
        dir_rows.push_back(row);
    endfunction

    function automatic in_item_t rand_beat(input opcode_t op);
        return mk_beat(op, WORD_W'($urandom_range(0, 4095)));
    endfunction

    // 0: no idling, 1: sender idle, 2: receiver stalls, 3: both lightly
    task automatic set_idle_mode(input int mode);
        case (mode)
            1:       begin src_idle_pct = 61; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 61; end
            3:       begin src_idle_pct = 6;  sink_stall_pct = 6;  end
            default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        endcase
    endtask

    // Offer one beat, hold it until accepted, then record what it should yield
    task automatic send_beat(input in_item_t beat, input bit typed, input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = rx_ring_predict(beat);
        expected_q.push_back(typed ? want : predicted);
    endtask

    // Hold off until every outstanding result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_enable(input logic val);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we     <= 1'b0;
        rx_enabled  = val;
    endtask

    // Result side: random back-pressure and comparison with the oldest expectation
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result %p", $time, out_data);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.status !== want.status || out_data.read_byte !== want.read_byte ||
                    out_data.fill_count !== want.fill_count ||
                    out_data.error_total !== want.error_total)
                begin
                    n_errors++;
                    $display("%0t: mismatch status exp %0d got %0d, byte exp %h got %h",
                             $time, want.status, out_data.status,
                             want.read_byte, out_data.read_byte);
                    $display("%0t:          fill exp %0d got %0d, errors exp %0d got %0d",
                             $time, want.fill_count, out_data.fill_count,
                             want.error_total, out_data.error_total);
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("uart_rx_ring_with_error_count_tb NOT OK");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int       ep;
        int       n;
        int       sent;
        episode_t kind;
        int       pick;

        // Disabled after reset: everything refused, nothing held
        add_row(0, 0, mk_beat(OP_PUSH,    12'hFFF), 1, mk_res(ST_OFF, 8'h00, 0, 0));
        add_row(0, 0, mk_beat(OP_POP,     12'h000), 1, mk_res(ST_OFF, 8'h00, 0, 0));
        add_row(0, 0, mk_beat(OP_FLUSH,   12'hFFF), 1, mk_res(ST_OFF, 8'h00, 0, 0));
        add_row(0, 0, mk_beat(OP_RESTART, 12'hFFF), 1, mk_res(ST_OFF, 8'h00, 0, 0));
        // Enabled: empty pop, data extremes, all flags, then each flag alone
        add_row(1, 1, mk_beat(OP_POP,     12'h000), 1, mk_res(ST_EMPTY, 8'h00, 0, 0));
        add_row(0, 0, mk_beat(OP_PUSH,    12'h000), 1, mk_res(ST_OK, 8'h00, 1, 0));
        add_row(0, 0, mk_beat(OP_PUSH,    12'h0FF), 1, mk_res(ST_OK, 8'h00, 2, 0));
        add_row(0, 0, mk_beat(OP_PUSH,    12'hFFF), 1, mk_res(ST_OK, 8'h00, 3, 4));
        add_row(0, 0, mk_beat(OP_PUSH,    12'h1A5), 1, mk_res(ST_OK, 8'h00, 4, 5));
        add_row(0, 0, mk_beat(OP_PUSH,    12'h25A), 1, mk_res(ST_OK, 8'h00, 5, 6));
        add_row(0, 0, mk_beat(OP_PUSH,    12'h43C), 1, mk_res(ST_OK, 8'h00, 6, 7));
        add_row(0, 0, mk_beat(OP_PUSH,    12'h8C3), 1, mk_res(ST_OK, 8'h00, 7, 8));
        add_row(0, 0, mk_beat(OP_POP,     12'h000), 1, mk_res(ST_OK, 8'h00, 6, 8));
        add_row(0, 0, mk_beat(OP_POP,     12'h000), 1, mk_res(ST_OK, 8'hFF, 5, 8));
        // flag bits on a pop are ignored
        add_row(0, 0, mk_beat(OP_POP,     12'hF00), 1, mk_res(ST_OK, 8'hFF, 4, 8));
        add_row(0, 0, mk_beat(OP_POP,     12'hFFF), 0, '0);
        add_row(0, 0, mk_beat(OP_FLUSH,   12'hFFF), 1, mk_res(ST_OK, 8'h00, 0, 8));
        add_row(0, 0, mk_beat(OP_POP,     12'h000), 1, mk_res(ST_EMPTY, 8'h00, 0, 8));
        add_row(0, 0, mk_beat(OP_PUSH,    12'h077), 1, mk_res(ST_OK, 8'h00, 1, 8));
        add_row(0, 0, mk_beat(OP_RESTART, 12'hF0F), 1, mk_res(ST_OK, 8'h00, 0, 0));
        add_row(0, 0, mk_beat(OP_PUSH,    12'h955), 1, mk_res(ST_OK, 8'h00, 1, 2));
        // Disabled again: state frozen but reported
        add_row(1, 0, mk_beat(OP_PUSH,    12'h0AA), 1, mk_res(ST_OFF, 8'h00, 1, 2));
        add_row(0, 0, mk_beat(OP_POP,     12'h000), 1, mk_res(ST_OFF, 8'h00, 1, 2));
        add_row(0, 0, mk_beat(OP_RESTART, 12'h000), 1, mk_res(ST_OFF, 8'h00, 1, 2));
        add_row(1, 1, mk_beat(OP_POP,     12'h000), 1, mk_res(ST_OK, 8'h55, 0, 2));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_en)
                write_enable(dir_rows[i].en_val);
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random episodes; refused beats do not count towards the total
        sent = 0;
        for (ep = 0; sent < RANDOM_BEATS || ep < 8; ep++)
        begin
            set_idle_mode(ep % 4);
            if (ep % 5 == 4)
            begin
                write_enable(1'b0);
                n = $urandom_range(6, 12);
                repeat (n) send_beat(rand_beat(opcode_t'($urandom_range(0, 3))), 0, '0);
                write_enable(1'b1);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (ep == 0)
                    kind = EP_FILL;
                else if (ep == 1)
                    kind = EP_DRAIN;
                else if (pick < 60)
                    kind = EP_MIXED;
                else if (pick < 70)
                    kind = EP_FILL;
                else if (pick < 85)
                    kind = EP_DRAIN;
                else
                    kind = EP_NOISE;

                case (kind)
                    EP_FILL:
                    begin
                        // fill to the brim, then overflow with random flags
                        n = 0;
                        while (!ring_full() && n < 300)
                        begin
                            send_beat(rand_beat(OP_PUSH), 0, '0);
                            n++;
                        end
                        repeat ($urandom_range(1, 4))
                        begin
                            send_beat(rand_beat(OP_PUSH), 0, '0);
                            n++;
                        end
                    end
                    EP_DRAIN:
                    begin
                        n = 0;
                        while (wr_ptr != rd_ptr)
                        begin
                            send_beat(rand_beat(OP_POP), 0, '0);
                            n++;
                        end
                        repeat ($urandom_range(1, 3))
                        begin
                            send_beat(rand_beat(OP_POP), 0, '0);
                            n++;
                        end
                    end
                    EP_MIXED:
                    begin
                        n = $urandom_range(30, 60);
                        repeat (n)
                        begin
                            pick = $urandom_range(0, 99);
                            if ($urandom_range(0, 99) < 3)
                                wait_drained();
                            if (pick < 45)
                                send_beat(rand_beat(OP_PUSH), 0, '0);
                            else if (pick < 85)
                                send_beat(rand_beat(OP_POP), 0, '0);
                            else if (pick < 93)
                                send_beat(rand_beat(OP_FLUSH), 0, '0);
                            else
                                send_beat(rand_beat(OP_RESTART), 0, '0);
                        end
                    end
                    default:
                    begin
                        n = $urandom_range(10, 20);
                        repeat (n) send_beat(rand_beat(opcode_t'($urandom_range(0, 3))), 0, '0);
                    end
                endcase
                sent += n;
            end
        end

        wait_drained();
        repeat (5) @(posedge clk);
        if (n_errors == 0)
            $display("uart_rx_ring_with_error_count_tb OK");
        else
            $display("uart_rx_ring_with_error_count_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/urx_pkg.sv
hw/rtl/urx_ram.sv
hw/rtl/urx_datapath.sv
hw/rtl/urx_ctrl.sv
hw/rtl/uart_rx_ring_with_error_count.sv
verif/uart_rx_ring_with_error_count_tb.sv
